>>> src/bfx_pkg.sv
// Shared types, sizes and codes of the bit field extract and insert block.
package bfx_pkg;

  localparam int unsigned BUF_BYTES      = 256;
  localparam int unsigned MAX_FIELD_BITS = 64;
  localparam int unsigned BUF_BITS       = BUF_BYTES * 8;

  localparam int FIELD_W = 64;
  localparam int MASK_W  = FIELD_W + 1;
  localparam int SIDX_W  = $clog2(FIELD_W);
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 11;
  localparam int WID_W   = 7;
  localparam int END_W   = 12;
  localparam int LEN_W   = $clog2(BUF_BYTES + 1);
  localparam int ADDR_W  = $clog2(BUF_BYTES);

  // The store is split into byte lanes so that a field window never hits
  // one lane twice; each lane has its own write enable.
  localparam int LANES      = 16;
  localparam int LANE_SEL_W = $clog2(LANES);
  localparam int ROWS       = BUF_BYTES / LANES;
  localparam int ROW_AW     = ADDR_W - LANE_SEL_W;

  // Bytes a field can touch, bit offset within the first byte included.
  localparam int unsigned WIN_BYTES = (MAX_FIELD_BITS + 14) / 8;
  localparam int unsigned WIN_BITS  = WIN_BYTES * 8;
  localparam int WB_SEL_W = $clog2(WIN_BYTES);
  localparam int SH_W     = $clog2(WIN_BITS + 1);

  // Queue between front and back; the depth must be a power of two.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_EXTRACT = 2'd2,
    ACT_INSERT  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_WIDE      = 2'd1,
    ST_BAD_WIDTH = 2'd2,
    ST_FULL      = 2'd3
  } stat_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               msb;
    logic               sext;
    logic [POS_W-1:0]   pos;
    logic [WID_W-1:0]   width;
    logic [FIELD_W-1:0] field;
    logic [BYTE_W-1:0]  byte_in;
  } req_t;

  typedef struct packed {
    act_t               op;
    logic               access;
    logic               grow;
    logic               msb;
    logic               sext;
    logic [WID_W-1:0]   width;
    logic [SH_W-1:0]    shamt;
    logic [ADDR_W-1:0]  start;
    logic [FIELD_W-1:0] field;
    logic [BYTE_W-1:0]  byte_in;
    logic [LEN_W-1:0]   old_fill;
    logic [LEN_W-1:0]   new_fill;
    logic [END_W-1:0]   end_bit;
    stat_t              status;
  } cmd_t;

endpackage

>>> src/bfx_ram.sv
// Generic simple dual port RAM with a registered read.
module bfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bfx_front.sv
// Front end: accepts requests, tracks the fill length and classifies each request.
module bfx_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  bfx_pkg::req_t   req,
  input  logic            q_full,
  output logic            push,
  output bfx_pkg::cmd_t   cmd
);

  logic [bfx_pkg::LEN_W-1:0] fill;

  assign push = req_valid && !q_full;

  always_comb begin
    logic [bfx_pkg::END_W-1:0]   end_sum;
    logic [bfx_pkg::LEN_W+2:0]   total;
    logic [bfx_pkg::LEN_W-1:0]   need;
    logic [2:0]                  ofs;

    end_sum = bfx_pkg::END_W'(req.pos) + bfx_pkg::END_W'(req.width);
    total   = {fill, 3'b000};
    need    = bfx_pkg::LEN_W'((32'(end_sum) + 32'd7) >> 3);
    ofs     = req.pos[2:0];

    cmd.op       = bfx_pkg::act_t'(req.action);
    cmd.access   = 1'b0;
    cmd.grow     = 1'b0;
    cmd.msb      = req.msb;
    cmd.sext     = req.sext;
    cmd.width    = req.width;
    cmd.shamt    = '0;
    cmd.start    = bfx_pkg::ADDR_W'(req.pos >> 3);
    cmd.field    = req.field;
    cmd.byte_in  = req.byte_in;
    cmd.old_fill = fill;
    cmd.new_fill = fill;
    cmd.end_bit  = '0;
    cmd.status   = bfx_pkg::ST_OK;

    case (bfx_pkg::act_t'(req.action))
      bfx_pkg::ACT_CLEAR: begin
        cmd.new_fill = '0;
      end
      bfx_pkg::ACT_APPEND: begin
        if (32'(fill) < bfx_pkg::BUF_BYTES) begin
          cmd.new_fill = fill + bfx_pkg::LEN_W'(1);
        end else begin
          cmd.status = bfx_pkg::ST_FULL;
        end
      end
      bfx_pkg::ACT_EXTRACT: begin
        if (32'(req.width) > bfx_pkg::MAX_FIELD_BITS) begin
          cmd.status = bfx_pkg::ST_WIDE;
        end else if (req.width != '0 && 32'(req.pos) < 32'(total)) begin
          cmd.access = 1'b1;
          // Clamp the field to the end of the filled bytes.
          if (32'(end_sum) > 32'(total)) begin
            cmd.width = bfx_pkg::WID_W'(32'(total) - 32'(req.pos));
          end
        end
      end
      bfx_pkg::ACT_INSERT: begin
        if (req.width == '0 || 32'(req.width) > bfx_pkg::MAX_FIELD_BITS) begin
          cmd.status = bfx_pkg::ST_BAD_WIDTH;
        end else if (32'(end_sum) > bfx_pkg::BUF_BITS) begin
          cmd.status = bfx_pkg::ST_FULL;
        end else begin
          cmd.access  = 1'b1;
          cmd.end_bit = end_sum;
          if (need > fill) begin
            cmd.grow     = 1'b1;
            cmd.new_fill = need;
          end
        end
      end
      default: begin
        cmd.status = bfx_pkg::ST_OK;
      end
    endcase

    // Right shift that brings the field's low bit to bit zero of the window.
    if (req.msb) begin
      cmd.shamt = bfx_pkg::SH_W'(bfx_pkg::WIN_BITS - 32'(ofs) - 32'(cmd.width));
    end else begin
      cmd.shamt = bfx_pkg::SH_W'(ofs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (push) begin
      fill <= cmd.new_fill;
    end
  end

endmodule

>>> src/bfx_queue.sv
// Short command queue between the front end and the back end.
module bfx_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bfx_pkg::cmd_t din,
  input  logic          pop,
  output bfx_pkg::cmd_t dout,
  output logic          not_empty,
  output logic          full
);

  bfx_pkg::cmd_t entry [bfx_pkg::Q_DEPTH];

  logic [bfx_pkg::Q_PTR_W-1:0] wp;
  logic [bfx_pkg::Q_PTR_W-1:0] rp;
  logic [bfx_pkg::Q_CNT_W-1:0] count;

  assign dout      = entry[rp];
  assign not_empty = count != '0;
  assign full      = 32'(count) == bfx_pkg::Q_DEPTH;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= din;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + bfx_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rp <= rp + bfx_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + bfx_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - bfx_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> src/bfx_back.sv
// Back end: byte lane store, zero fill sweep, field extract and insert, result register.
module bfx_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  bfx_pkg::cmd_t                head,
  output logic                         pop,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [bfx_pkg::FIELD_W-1:0]  rsp_field,
  output logic [bfx_pkg::END_W-1:0]    rsp_end,
  output logic [bfx_pkg::LEN_W-1:0]    rsp_len,
  output logic [1:0]                   rsp_status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ZERO,
    S_READ,
    S_EXEC
  } state_t;

  state_t                       state;
  bfx_pkg::cmd_t                cur;
  logic [bfx_pkg::ROW_AW-1:0]   zaddr;
  logic                         zlast;
  logic                         rsp_load;

  logic                         ram_we    [bfx_pkg::LANES];
  logic [bfx_pkg::ROW_AW-1:0]   ram_waddr [bfx_pkg::LANES];
  logic [bfx_pkg::BYTE_W-1:0]   ram_wdata [bfx_pkg::LANES];
  logic [bfx_pkg::ROW_AW-1:0]   ram_raddr [bfx_pkg::LANES];
  logic [bfx_pkg::BYTE_W-1:0]   ram_rdata [bfx_pkg::LANES];

  bfx_pkg::cmd_t                src;
  logic [bfx_pkg::LANE_SEL_W-1:0] rot;
  logic [bfx_pkg::ROW_AW-1:0]   base;

  logic [bfx_pkg::WIN_BITS-1:0] flat_le;
  logic [bfx_pkg::WIN_BITS-1:0] flat_be;
  logic [bfx_pkg::WIN_BITS-1:0] flat;
  logic [bfx_pkg::WIN_BITS-1:0] shifted;
  logic [bfx_pkg::WIN_BITS-1:0] ins_w;
  logic [bfx_pkg::WIN_BITS-1:0] msk_w;
  logic [bfx_pkg::FIELD_W-1:0]  fmask;
  logic [bfx_pkg::FIELD_W-1:0]  fval;
  logic [bfx_pkg::FIELD_W-1:0]  fext;
  logic [bfx_pkg::SIDX_W-1:0]   sidx;
  logic [bfx_pkg::BYTE_W-1:0]   mb [bfx_pkg::WIN_BYTES];
  logic [bfx_pkg::BYTE_W-1:0]   vb [bfx_pkg::WIN_BYTES];

  for (genvar g = 0; g < bfx_pkg::LANES; g++) begin : g_lane
    bfx_ram #(
      .WIDTH(bfx_pkg::BYTE_W),
      .DEPTH(bfx_pkg::ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we[g]),
      .waddr(ram_waddr[g]),
      .wdata(ram_wdata[g]),
      .raddr(ram_raddr[g]),
      .rdata(ram_rdata[g])
    );
  end

  assign pop = (state == S_IDLE) && head_valid && (!rsp_valid || !rsp_stall);

  // A new result is loaded for a request that needs no store access, or at
  // the end of an access.
  assign rsp_load = (state == S_IDLE && pop && !head.grow && !head.access)
                    || (state == S_EXEC);

  assign rot   = cur.start[bfx_pkg::LANE_SEL_W-1:0];
  assign base  = cur.start[bfx_pkg::ADDR_W-1:bfx_pkg::LANE_SEL_W];
  assign zlast = zaddr == bfx_pkg::ROW_AW'((32'(cur.new_fill) - 32'd1) >> bfx_pkg::LANE_SEL_W);

  // Lanes below the window's first lane hold bytes of the next row.
  always_comb begin
    src = (state == S_IDLE) ? head : cur;
    for (int l = 0; l < bfx_pkg::LANES; l++) begin
      ram_raddr[l] = src.start[bfx_pkg::ADDR_W-1:bfx_pkg::LANE_SEL_W]
                   + bfx_pkg::ROW_AW'(bfx_pkg::LANE_SEL_W'(l)
                                      < src.start[bfx_pkg::LANE_SEL_W-1:0]);
    end
  end

  // Gather the window in stream order, shift and mask the field, build the insert bytes.
  always_comb begin
    for (int k = 0; k < bfx_pkg::WIN_BYTES; k++) begin
      flat_le[k*bfx_pkg::BYTE_W +: bfx_pkg::BYTE_W] =
        ram_rdata[bfx_pkg::LANE_SEL_W'(rot + bfx_pkg::LANE_SEL_W'(k))];
      flat_be[(bfx_pkg::WIN_BYTES-1-k)*bfx_pkg::BYTE_W +: bfx_pkg::BYTE_W] =
        ram_rdata[bfx_pkg::LANE_SEL_W'(rot + bfx_pkg::LANE_SEL_W'(k))];
    end
    flat    = cur.msb ? flat_be : flat_le;
    shifted = flat >> cur.shamt;
    fmask   = bfx_pkg::FIELD_W'((bfx_pkg::MASK_W'(1) << cur.width) - bfx_pkg::MASK_W'(1));
    fval    = bfx_pkg::FIELD_W'(shifted) & fmask;
    sidx    = bfx_pkg::SIDX_W'(cur.width - bfx_pkg::WID_W'(1));
    fext    = fval;
    if (cur.sext && 32'(cur.width) < bfx_pkg::FIELD_W && fval[sidx]) begin
      fext = fval | ~fmask;
    end
    ins_w = bfx_pkg::WIN_BITS'(cur.field & fmask) << cur.shamt;
    msk_w = bfx_pkg::WIN_BITS'(fmask) << cur.shamt;
    for (int k = 0; k < bfx_pkg::WIN_BYTES; k++) begin
      if (cur.msb) begin
        mb[k] = msk_w[(bfx_pkg::WIN_BYTES-1-k)*bfx_pkg::BYTE_W +: bfx_pkg::BYTE_W];
        vb[k] = ins_w[(bfx_pkg::WIN_BYTES-1-k)*bfx_pkg::BYTE_W +: bfx_pkg::BYTE_W];
      end else begin
        mb[k] = msk_w[k*bfx_pkg::BYTE_W +: bfx_pkg::BYTE_W];
        vb[k] = ins_w[k*bfx_pkg::BYTE_W +: bfx_pkg::BYTE_W];
      end
    end
  end

  // Lane write ports: append byte, zero fill row, or merged insert bytes.
  always_comb begin
    logic [bfx_pkg::LANE_SEL_W-1:0] k;
    logic [bfx_pkg::WB_SEL_W-1:0]   kk;
    logic [bfx_pkg::ADDR_W-1:0]     bidx;
    for (int l = 0; l < bfx_pkg::LANES; l++) begin
      k            = bfx_pkg::LANE_SEL_W'(l) - rot;
      kk           = bfx_pkg::WB_SEL_W'(k);
      bidx         = {zaddr, bfx_pkg::LANE_SEL_W'(l)};
      ram_we[l]    = 1'b0;
      ram_waddr[l] = base + bfx_pkg::ROW_AW'(bfx_pkg::LANE_SEL_W'(l) < rot);
      ram_wdata[l] = '0;
      case (state)
        S_IDLE: begin
          ram_waddr[l] = head.old_fill[bfx_pkg::ADDR_W-1:bfx_pkg::LANE_SEL_W];
          ram_wdata[l] = head.byte_in;
          ram_we[l]    = pop && head.op == bfx_pkg::ACT_APPEND
                         && head.status == bfx_pkg::ST_OK
                         && head.old_fill[bfx_pkg::LANE_SEL_W-1:0]
                            == bfx_pkg::LANE_SEL_W'(l);
        end
        S_ZERO: begin
          ram_waddr[l] = zaddr;
          ram_we[l]    = 32'(bidx) >= 32'(cur.old_fill) && 32'(bidx) < 32'(cur.new_fill);
        end
        S_EXEC: begin
          if (cur.op == bfx_pkg::ACT_INSERT && 32'(k) < bfx_pkg::WIN_BYTES) begin
            ram_we[l]    = mb[kk] != '0;
            ram_wdata[l] = (ram_rdata[l] & ~mb[kk]) | vb[kk];
          end
        end
        default: begin
          ram_we[l] = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= head;
            if (head.grow) begin
              zaddr <= head.old_fill[bfx_pkg::ADDR_W-1:bfx_pkg::LANE_SEL_W];
              state <= S_ZERO;
            end else if (head.access) begin
              state <= S_EXEC;
            end else begin
              rsp_field  <= '0;
              rsp_end    <= head.end_bit;
              rsp_len    <= head.new_fill;
              rsp_status <= head.status;
            end
          end
        end
        S_ZERO: begin
          zaddr <= zaddr + bfx_pkg::ROW_AW'(1);
          if (zlast) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          rsp_field  <= (cur.op == bfx_pkg::ACT_EXTRACT) ? fext : '0;
          rsp_end    <= cur.end_bit;
          rsp_len    <= cur.new_fill;
          rsp_status <= cur.status;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/bit_field_extract_insert_top.sv
// Top level of the bit field extract and insert block over a byte buffer.
//
//   channel   handshake              payload
//   request   req_valid / req_stall  action msb_first sign_extend bit_pos bit_width
//                                    field_in byte_in
//   result    rsp_valid / rsp_stall  field_out end_bit length_bytes status
//
// Requests that need no store access (clears, appends, rejected requests and
// extracts that touch no filled byte) are answered from the idle state. Any
// other extract or insert reads the two store rows that hold the field, then
// shifts out or merges and writes back the field bytes in the execute state.
// A growing insert first zeroes the new bytes, one 16-byte row per cycle with
// at most 16 rows, then passes through a read state. The front end classifies a
// request in the cycle it is taken, so requests are taken while the two-entry
// queue has room. Reset clears the fill length, the queue and the result
// valid flag, not the store; only bytes below the fill length are read. A
// stalled result holds its register while the front keeps filling the queue.
module bit_field_extract_insert_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         action,
  input  logic                               msb_first,
  input  logic                               sign_extend,
  input  logic [bfx_pkg::POS_W-1:0]          bit_pos,
  input  logic [bfx_pkg::WID_W-1:0]          bit_width,
  input  logic signed [bfx_pkg::FIELD_W-1:0] field_in,
  input  logic [bfx_pkg::BYTE_W-1:0]         byte_in,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic signed [bfx_pkg::FIELD_W-1:0] field_out,
  output logic [bfx_pkg::END_W-1:0]          end_bit,
  output logic [bfx_pkg::LEN_W-1:0]          length_bytes,
  output logic [1:0]                         status
);

  bfx_pkg::req_t req;
  bfx_pkg::cmd_t push_cmd;
  bfx_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;

  // Pack the request ports for the front end.
  assign req.action  = action;
  assign req.msb     = msb_first;
  assign req.sext    = sign_extend;
  assign req.pos     = bit_pos;
  assign req.width   = bit_width;
  assign req.field   = field_in;
  assign req.byte_in = byte_in;

  // A request waits only when the queue has no free entry.
  assign req_stall = q_full;

  bfx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  bfx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (push_cmd),
    .pop      (pop),
    .dout     (head_cmd),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  bfx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_not_empty),
    .head      (head_cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_field (field_out),
    .rsp_end   (end_bit),
    .rsp_len   (length_bytes),
    .rsp_status(status)
  );

endmodule

>>> sim/tb_bit_field_extract_insert_top.sv
// Self-checking testbench for the bit field extract and insert block.
module tb_bit_field_extract_insert_top;
  import bfx_pkg::*;

  // Request as the stimulus queue holds it. A set hold_back bit makes the
  // sender wait until every outstanding result has come back before it
  // offers this request.
  typedef struct {
    act_t               act;
    logic               msb;
    logic               sext;
    logic [POS_W-1:0]   pos;
    logic [WID_W-1:0]   wid;
    logic [FIELD_W-1:0] fld;
    logic [BYTE_W-1:0]  byt;
    bit                 hold_back;
  } field_req_s;

  // One result as the block should return it.
  typedef struct {
    logic [FIELD_W-1:0] field;
    logic [END_W-1:0]   end_pos;
    logic [LEN_W-1:0]   len;
    stat_t              status;
  } field_rsp_s;

  localparam int N_RANDOM     = 850;
  localparam int STALL_AT     = 250;  // accepted requests before the long hold-off
  localparam int STALL_CYCLES = 100;
  localparam int TAIL_CYCLES  = 40;   // outlasts the longest insert with growth

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every block input starts at a known value.
  logic                      req_valid   = 1'b0;
  logic                      rsp_stall   = 1'b0;
  logic [1:0]                action      = ACT_CLEAR;
  logic                      msb_first   = 1'b0;
  logic                      sign_extend = 1'b0;
  logic [POS_W-1:0]          bit_pos     = '0;
  logic [WID_W-1:0]          bit_width   = '0;
  logic signed [FIELD_W-1:0] field_in    = '0;
  logic [BYTE_W-1:0]         byte_in     = '0;

  logic                      req_stall;
  logic                      rsp_valid;
  logic signed [FIELD_W-1:0] field_out;
  logic [END_W-1:0]          end_bit;
  logic [LEN_W-1:0]          length_bytes;
  logic [1:0]                status;

  bit_field_extract_insert_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .msb_first    (msb_first),
    .sign_extend  (sign_extend),
    .bit_pos      (bit_pos),
    .bit_width    (bit_width),
    .field_in     (field_in),
    .byte_in      (byte_in),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .field_out    (field_out),
    .end_bit      (end_bit),
    .length_bytes (length_bytes),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the byte buffer and its fill length. Only bytes below
  // the fill length are ever read, so the shadow needs no reset of its own.
  logic [BYTE_W-1:0] shadow_bytes [BUF_BYTES];
  int unsigned       shadow_fill;

  field_req_s pending_reqs [$];
  field_rsp_s expected_rsps [$];
  int         n_total;
  int         n_taken;
  int         n_errors;
  logic       req_fire = 1'b0;

  // Receiver hold-off state, owned by the receiver process.
  int  stall_left = 0;
  bit  stall_done = 1'b0;

  // Compute the result of one request and update the shadow buffer.
  function automatic field_rsp_s predict_field_op(field_req_s r);
    field_rsp_s  res;
    int unsigned total;
    int unsigned w;
    int unsigned p;
    int unsigned b;
    int unsigned sh;
    int unsigned need;
    res.field   = '0;
    res.end_pos = '0;
    res.status  = ST_OK;
    w = 32'(r.wid);
    p = 32'(r.pos);
    case (r.act)
      ACT_CLEAR: begin
        shadow_fill = 0;
      end
      ACT_APPEND: begin
        if (shadow_fill < BUF_BYTES) begin
          shadow_bytes[shadow_fill] = r.byt;
          shadow_fill++;
        end else begin
          res.status = ST_FULL;
        end
      end
      ACT_EXTRACT: begin
        total = shadow_fill * 8;
        if (w > MAX_FIELD_BITS) begin
          res.status = ST_WIDE;
        end else if (w > 0 && p < total) begin
          // Clamp to the end of the buffer; sign extension uses this width.
          if (p + w > total) w = total - p;
          for (int unsigned i = 0; i < w; i++) begin
            b  = r.msb ? (p + w - 1 - i) : (p + i);
            sh = r.msb ? (7 - (b & 7)) : (b & 7);
            res.field[i] = shadow_bytes[b >> 3][sh];
          end
          if (r.sext && w < 64 && res.field[w-1]) begin
            for (int unsigned i = w; i < 64; i++) res.field[i] = 1'b1;
          end
        end
      end
      default: begin
        if (w == 0 || w > MAX_FIELD_BITS) begin
          res.status = ST_BAD_WIDTH;
        end else if (p + w > BUF_BITS) begin
          res.status = ST_FULL;
        end else begin
          // Grow with zero bytes first, then write the field bits.
          need = (p + w + 7) >> 3;
          while (shadow_fill < need) begin
            shadow_bytes[shadow_fill] = '0;
            shadow_fill++;
          end
          for (int unsigned i = 0; i < w; i++) begin
            b  = r.msb ? (p + w - 1 - i) : (p + i);
            sh = r.msb ? (7 - (b & 7)) : (b & 7);
            shadow_bytes[b >> 3][sh] = r.fld[i];
          end
          res.end_pos = END_W'(p + w);
        end
      end
    endcase
    res.len = LEN_W'(shadow_fill);
    return res;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h (result %0d)",
             what, got, want, n_taken);
    n_errors++;
  endtask

  task automatic queue_req(act_t a, int m, int s, int p, int w,
                           logic [63:0] f, int y, int hb);
    field_req_s r;
    r.act       = a;
    r.msb       = 1'(m);
    r.sext      = 1'(s);
    r.pos       = POS_W'(p);
    r.wid       = WID_W'(w);
    r.fld       = f;
    r.byt       = BYTE_W'(y);
    r.hold_back = (hb != 0);
    pending_reqs.push_back(r);
  endtask

  // Idle percentage for one side. The run is split into three thirds by
  // accepted requests: sender idles 19% and receiver 53% first, then the
  // other way round, then neither side idles.
  function automatic int idle_pct(bit receiver);
    if (n_taken < n_total / 3) return receiver ? 53 : 19;
    if (n_taken < (2 * n_total) / 3) return receiver ? 19 : 53;
    return 0;
  endfunction

  // Sender. Inputs change on the falling edge only. A request that was
  // offered and not taken stays on the ports unchanged.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_fire) begin
      // Held by the block; keep the request as it is.
    end else if (pending_reqs.size() == 0) begin
      req_valid <= 1'b0;
    end else if (pending_reqs[0].hold_back && expected_rsps.size() != 0) begin
      // Pause until every outstanding result has come back.
      req_valid <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct(1'b0)) begin
      req_valid <= 1'b0;
    end else begin
      field_req_s nxt;
      nxt = pending_reqs.pop_front();
      action      <= nxt.act;
      msb_first   <= nxt.msb;
      sign_extend <= nxt.sext;
      bit_pos     <= nxt.pos;
      bit_width   <= nxt.wid;
      field_in    <= nxt.fld;
      byte_in     <= nxt.byt;
      req_valid   <= 1'b1;
    end
  end

  // Receiver. Once, a long hold-off lets the sender keep offering until the
  // block's queue is full and it stalls its request side.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rst && !stall_done && n_taken >= STALL_AT) begin
      rsp_stall  <= 1'b1;
      stall_left <= STALL_CYCLES - 1;
      stall_done <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
    end
  end

  // Monitor. Sampling at the rising edge sees the values from before the
  // edge. A result is checked before the request taken at the same edge
  // is predicted, so a result cannot match its own request early.
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result", field_out, '0);
        end else begin
          field_rsp_s want;
          want = expected_rsps.pop_front();
          if (field_out !== want.field)
            report_mismatch("field_out", field_out, want.field);
          if (end_bit !== want.end_pos)
            report_mismatch("end_bit", 64'(end_bit), 64'(want.end_pos));
          if (length_bytes !== want.len)
            report_mismatch("length_bytes", 64'(length_bytes), 64'(want.len));
          if (status !== want.status)
            report_mismatch("status", 64'(status), 64'(want.status));
        end
      end
      if (req_valid && !req_stall) begin
        field_req_s got;
        got.act       = act_t'(action);
        got.msb       = msb_first;
        got.sext      = sign_extend;
        got.pos       = bit_pos;
        got.wid       = bit_width;
        got.fld       = field_in;
        got.byt       = byte_in;
        got.hold_back = 1'b0;
        expected_rsps.push_back(predict_field_op(got));
        n_taken++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int          sel;
    int          r;
    act_t        a;
    int          p;
    int          w;
    logic [63:0] f;
    n_taken     = 0;
    n_errors    = 0;
    shadow_fill = 0;

    // Directed part: empty buffer, appends, every kind of rejection, the
    // clamp at the end of the buffer, sign extension and growth.
    queue_req(ACT_CLEAR,   1, 0,    0,   8, '0, 8'h00, 0);
    queue_req(ACT_EXTRACT, 1, 1,    0,   8, '0, 8'h00, 0);  // empty buffer
    queue_req(ACT_APPEND,  0, 0,    0,   0, '0, 8'h00, 0);
    queue_req(ACT_APPEND,  0, 0,    0,   0, '0, 8'hFF, 0);
    queue_req(ACT_APPEND,  0, 0,    0,   0, '0, 8'hA5, 0);
    queue_req(ACT_APPEND,  0, 0,    0,   0, '0, 8'h3C, 0);
    queue_req(ACT_EXTRACT, 1, 0,    8,   8, '0, 8'h00, 0);
    queue_req(ACT_EXTRACT, 0, 1,    4,  12, '0, 8'h00, 0);
    queue_req(ACT_EXTRACT, 1, 1,    4,   0, '0, 8'h00, 0);  // zero width
    queue_req(ACT_EXTRACT, 0, 0,    0,  65, '0, 8'h00, 0);  // too wide
    queue_req(ACT_EXTRACT, 1, 1,    0, 127, '0, 8'h00, 0);  // too wide
    queue_req(ACT_EXTRACT, 1, 1,   20,  40, '0, 8'h00, 0);  // clamped
    queue_req(ACT_EXTRACT, 0, 1,   32,   8, '0, 8'h00, 0);  // at the end
    queue_req(ACT_INSERT,  1, 0,    0,   0, '1, 8'h00, 1);  // zero width
    queue_req(ACT_INSERT,  0, 0,    0,  65, '1, 8'h00, 0);  // too wide
    queue_req(ACT_INSERT,  1, 0, 2047,   2, '1, 8'h00, 0);  // past capacity
    queue_req(ACT_INSERT,  1, 0, 2000,  48, 64'h8000_1234_5678_9ABC, 8'h00, 0);
    queue_req(ACT_APPEND,  0, 0,    0,   0, '0, 8'h77, 0);  // buffer full
    queue_req(ACT_INSERT,  0, 0, 1984,  64, 64'h8123_4567_89AB_CDEF, 8'h00, 0);
    queue_req(ACT_EXTRACT, 0, 1, 1984,  64, '0, 8'h00, 0);  // full 64 bits
    queue_req(ACT_EXTRACT, 1, 1, 2047,  64, '0, 8'h00, 0);  // one bit left
    queue_req(ACT_CLEAR,   0, 0,    0,   0, '0, 8'h00, 0);
    queue_req(ACT_INSERT,  1, 0,  101,  13, 64'h0000_0000_0000_1ABC, 8'h00, 0);
    queue_req(ACT_EXTRACT, 1, 1,  101,  13, '0, 8'h00, 0);
    queue_req(ACT_EXTRACT, 0, 1,   96,  64, '0, 8'h00, 0);

    // Random part. Mostly legal operations on a buffer of modest size with
    // random content; a share of positions spans the whole range and a
    // share of widths is zero or too wide.
    for (int k = 0; k < N_RANDOM; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) a = ACT_CLEAR;
      else if (sel < 30) a = ACT_APPEND;
      else if (sel < 65) a = ACT_EXTRACT;
      else a = ACT_INSERT;
      r = $urandom_range(0, 99);
      p = (r < 12) ? $urandom_range(0, 2047) : $urandom_range(0, 320);
      r = $urandom_range(0, 99);
      if (r < 8) w = $urandom_range(65, 127);
      else if (r < 11) w = 0;
      else if (r < 20) w = 64;
      else w = $urandom_range(1, 64);
      r = $urandom_range(0, 99);
      if (r < 10) f = '1;
      else if (r < 15) f = '0;
      else f = {$urandom, $urandom};
      queue_req(a, $urandom_range(0, 1), $urandom_range(0, 1), p, w, f,
                $urandom_range(0, 255), ((k == 400) || (k == 700)) ? 1 : 0);
    end
    n_total = pending_reqs.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_taken < n_total || expected_rsps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rsps.size() != 0)
      report_mismatch("results never delivered", '0, 64'(expected_rsps.size()));

    if (n_errors == 0) begin
      $display("tb_bit_field_extract_insert_top OK");
    end else begin
      $display("tb_bit_field_extract_insert_top NOT OK");
    end
    $finish;
  end

  // Hard limit on the run, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb_bit_field_extract_insert_top NOT OK");
    $finish;
  end

endmodule

>>> sim.f
src/bfx_pkg.sv
src/bfx_ram.sv
src/bfx_front.sv
src/bfx_queue.sv
src/bfx_back.sv
src/bit_field_extract_insert_top.sv
sim/tb_bit_field_extract_insert_top.sv
